### hw/rtl/sba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_pkg : shared definitions for the slab bitmap allocator
// Widths, bitmap geometry, parameter defaults and result status codes.
// ----------------------------------------------------------------------------
package sba_pkg;

  // Field widths
  localparam int IDX_W    = 13;
  localparam int CNT_W    = 14;
  localparam int SC_W     = 4;
  localparam int STATUS_W = 3;

  // Largest valid size class code
  localparam int SC_MAX = 9;

  // Bitmap geometry: one bit per block, stored as rows of MAP_W bits
  localparam int MAP_DEPTH = 8192;
  localparam int MAP_W     = 32;
  localparam int MAP_ROWS  = MAP_DEPTH / MAP_W;
  localparam int ROW_W     = $clog2(MAP_ROWS);
  localparam int BIT_W     = $clog2(MAP_W);

  // Saturation limit of the allocated count
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Parameter defaults
  localparam int SLAB_BYTES_DEF   = 65536;
  localparam int RING_DEPTH_DEF   = 64;
  localparam int REFILL_BATCH_DEF = 32;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_SLAB_FULL   = 3'd1,
    ST_OUT_OF_RANGE = 3'd2,
    ST_DOUBLE_FREE = 3'd3,
    ST_COUNT_ZERO  = 3'd4
  } status_t;

endpackage

### hw/rtl/slab_bitmap_allocator_with_free_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_bitmap_allocator_with_free_cache : slab block allocator
// Bitmap of taken blocks plus a ring cache of free block indices, run by a
// small sequencer over one bitmap memory and one ring memory.
// ----------------------------------------------------------------------------
// Usage
//   Requests: drive in_kind / in_block_index with start; the request is taken
//   at a clock edge where start is high, busy is low and cfg_valid is low. One
//   result per request appears on the out_ ports for exactly one cycle with
//   out_valid; the receiver cannot stall, so results are never held back.
//   Configuration: cfg_size_class is written when cfg_valid is high
//   (cfg_ready is always high). A write re-creates the slab.
// Steps after the accept edge; busy is low in the result cycle, so the next
// request may be taken at the edge that ends it
//   Free out of range, allocate with slab full and empty ring: from idle.
//   Allocate from the ring: ring read, pop. Free of a taken block: check,
//   push. Double free: check. Allocate on an empty ring: read, load and
//   scan per bitmap row visited, one more scan per reserved block, then
//   check and pop (no pop if no clear block is found). Free on a full
//   ring: check, ring read, row read, row clear per entry written back, push.
// Reset and configuration
//   After reset or a configuration write the bitmap is cleared one row a
//   cycle, all 256 rows, while busy is high and no request is taken.
// ----------------------------------------------------------------------------
module slab_bitmap_allocator_with_free_cache #(
  parameter int SLAB_BYTES   = sba_pkg::SLAB_BYTES_DEF,
  parameter int RING_DEPTH   = sba_pkg::RING_DEPTH_DEF,
  parameter int REFILL_BATCH = sba_pkg::REFILL_BATCH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_kind,
  input  logic [sba_pkg::IDX_W-1:0]  in_block_index,
  // result channel
  output logic                       out_valid,
  output sba_pkg::status_t           out_status,
  output logic [sba_pkg::IDX_W-1:0]  out_granted_index,
  output logic                       out_slab_full,
  output logic                       out_slab_empty,
  // configuration channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sba_pkg::SC_W-1:0]   cfg_size_class
);
  import sba_pkg::*;

  localparam int RW    = $clog2(RING_DEPTH);
  localparam int CW    = $clog2(RING_DEPTH + 1);
  localparam int LIMIT = (REFILL_BATCH < RING_DEPTH) ? REFILL_BATCH : RING_DEPTH;
  localparam int LEVEL = (REFILL_BATCH < RING_DEPTH) ? REFILL_BATCH : RING_DEPTH - 1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_LOAD,
    S_SCAN_BIT,
    S_ALLOC_CHK,
    S_POP_RD,
    S_POP_DONE,
    S_FREE_CHK,
    S_DRAIN_RD,
    S_DRAIN_MAP,
    S_DRAIN_CLR,
    S_PUSH
  } state_t;

  // Memories
  logic [MAP_W-1:0] map_mem [MAP_ROWS];
  logic [IDX_W-1:0] ring_mem [RING_DEPTH];
  logic [MAP_W-1:0] map_q;
  logic [IDX_W-1:0] ring_q;

  // Registers
  state_t            state_r;
  logic [SC_W-1:0]   size_class_r;
  logic [ROW_W-1:0]  clr_cnt_r;
  logic [RW-1:0]     head_r;
  logic [RW-1:0]     tail_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     got_r;
  logic [CNT_W-1:0]  alloc_r;
  logic [IDX_W-1:0]  idx_r;
  logic [ROW_W-1:0]  row_r;
  logic [BIT_W-1:0]  bit_r;
  logic [MAP_W-1:0]  rowbuf_r;
  status_t           status_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [IDX_W-1:0]  out_granted_r;
  logic              out_full_r;
  logic              out_empty_r;

  // Combinational control
  logic [31:0]       tot_wide;
  logic [CNT_W-1:0]  total;
  logic [MAP_W-1:0]  row_mask;
  logic [MAP_W-1:0]  cand;
  logic [BIT_W-1:0]  ffz;
  logic              ffz_found;
  logic [ROW_W:0]    row_next;
  logic              last_row;
  logic              scan_push;
  logic [CNT_W-1:0]  alloc_inc;
  logic              map_we;
  logic [ROW_W-1:0]  map_waddr;
  logic [MAP_W-1:0]  map_wdata;
  logic              map_re;
  logic [ROW_W-1:0]  map_raddr;
  logic              ring_we;
  logic [IDX_W-1:0]  ring_wdata;
  logic              ring_re;

  function automatic logic [RW-1:0] ptr_inc(input logic [RW-1:0] p);
    ptr_inc = (p == RW'(RING_DEPTH - 1)) ? '0 : p + RW'(1);
  endfunction

  // Block count from the size class, saturated at the bitmap depth, zero above SC_MAX
  always_comb begin
    tot_wide = 32'(SLAB_BYTES) >> (32'd3 + 32'(size_class_r));
    if (size_class_r > SC_W'(SC_MAX)) begin
      total = '0;
    end else if (tot_wide > 32'(MAP_DEPTH)) begin
      total = CNT_W'(MAP_DEPTH);
    end else begin
      total = CNT_W'(tot_wide);
    end
  end

  // Mask of in-range blocks within the current row
  always_comb begin
    if ({1'b0, row_r} < total[CNT_W-1:BIT_W]) begin
      row_mask = '1;
    end else if ({1'b0, row_r} == total[CNT_W-1:BIT_W]) begin
      row_mask = (MAP_W'(1) << total[BIT_W-1:0]) - MAP_W'(1);
    end else begin
      row_mask = '0;
    end
  end

  // Find the lowest clear in-range bit of the working row
  always_comb begin
    cand = ~rowbuf_r & row_mask;
    ffz  = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        ffz = BIT_W'(i);
      end
    end
    ffz_found = |cand;
  end

  assign row_next  = {1'b0, row_r} + (ROW_W+1)'(1);
  assign last_row  = {row_next, {BIT_W{1'b0}}} >= total;
  assign scan_push = (state_r == S_SCAN_BIT) && ffz_found && (got_r < CW'(LIMIT));
  assign alloc_inc = (alloc_r == COUNT_MAX) ? alloc_r : alloc_r + CNT_W'(1);

  // Memory port selection
  always_comb begin
    map_we     = 1'b0;
    map_waddr  = row_r;
    map_wdata  = rowbuf_r;
    map_re     = 1'b0;
    map_raddr  = row_r;
    ring_we    = 1'b0;
    ring_wdata = idx_r;
    ring_re    = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_cnt_r;
        map_wdata = '0;
      end
      S_IDLE: begin
        map_re    = start && in_kind;
        map_raddr = in_block_index[IDX_W-1:BIT_W];
      end
      S_SCAN_RD: begin
        map_re = 1'b1;
      end
      S_SCAN_BIT: begin
        if (scan_push) begin
          ring_we    = 1'b1;
          ring_wdata = {row_r, ffz};
        end else begin
          map_we = 1'b1;
        end
      end
      S_POP_RD, S_DRAIN_RD: begin
        ring_re = 1'b1;
      end
      S_DRAIN_MAP: begin
        map_re    = 1'b1;
        map_raddr = ring_q[IDX_W-1:BIT_W];
      end
      S_DRAIN_CLR: begin
        map_we    = 1'b1;
        map_wdata = map_q & ~(MAP_W'(1) << bit_r);
      end
      S_PUSH: begin
        ring_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Bitmap memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_q <= map_mem[map_raddr];
    end
  end

  // Ring memory: write at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[tail_r] <= ring_wdata;
    end
    if (ring_re) begin
      ring_q <= ring_mem[head_r];
    end
  end

  // Sequencer, counters and registered results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      size_class_r <= '0;
      clr_cnt_r    <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      alloc_r      <= '0;
      out_valid_r  <= 1'b0;
    end else if (cfg_valid) begin
      // re-create the slab on a configuration transfer
      size_class_r <= cfg_size_class;
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      alloc_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + ROW_W'(1);
          if (clr_cnt_r == ROW_W'(MAP_ROWS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            idx_r <= in_block_index;
            if (!in_kind) begin
              if (count_r != '0) begin
                state_r <= S_POP_RD;
              end else if (alloc_r >= total) begin
                out_valid_r   <= 1'b1;
                out_status_r  <= ST_SLAB_FULL;
                out_granted_r <= '0;
                out_full_r    <= (alloc_r == total);
                out_empty_r   <= (alloc_r == '0);
              end else begin
                row_r   <= '0;
                got_r   <= '0;
                state_r <= S_SCAN_RD;
              end
            end else if ({1'b0, in_block_index} >= total) begin
              out_valid_r   <= 1'b1;
              out_status_r  <= ST_OUT_OF_RANGE;
              out_granted_r <= '0;
              out_full_r    <= (alloc_r == total);
              out_empty_r   <= (alloc_r == '0);
            end else begin
              state_r <= S_FREE_CHK;
            end
          end
        end
        S_SCAN_RD: begin
          state_r <= S_SCAN_LOAD;
        end
        S_SCAN_LOAD: begin
          rowbuf_r <= map_q;
          state_r  <= S_SCAN_BIT;
        end
        S_SCAN_BIT: begin
          if (scan_push) begin
            // reserve one clear block into the ring
            rowbuf_r[ffz] <= 1'b1;
            got_r         <= got_r + CW'(1);
            tail_r        <= ptr_inc(tail_r);
            count_r       <= count_r + CW'(1);
          end else if (last_row || (got_r == CW'(LIMIT))) begin
            state_r <= S_ALLOC_CHK;
          end else begin
            row_r   <= row_next[ROW_W-1:0];
            state_r <= S_SCAN_RD;
          end
        end
        S_ALLOC_CHK: begin
          if (count_r == '0) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= ST_SLAB_FULL;
            out_granted_r <= '0;
            out_full_r    <= (alloc_r == total);
            out_empty_r   <= (alloc_r == '0);
            state_r       <= S_IDLE;
          end else begin
            state_r <= S_POP_RD;
          end
        end
        S_POP_RD: begin
          state_r <= S_POP_DONE;
        end
        S_POP_DONE: begin
          head_r        <= ptr_inc(head_r);
          count_r       <= count_r - CW'(1);
          alloc_r       <= alloc_inc;
          out_valid_r   <= 1'b1;
          out_status_r  <= ST_OK;
          out_granted_r <= ring_q;
          out_full_r    <= (alloc_inc == total);
          out_empty_r   <= (alloc_inc == '0);
          state_r       <= S_IDLE;
        end
        S_FREE_CHK: begin
          if (!map_q[idx_r[BIT_W-1:0]]) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= ST_DOUBLE_FREE;
            out_granted_r <= '0;
            out_full_r    <= (alloc_r == total);
            out_empty_r   <= (alloc_r == '0);
            state_r       <= S_IDLE;
          end else begin
            if (alloc_r != '0) begin
              alloc_r  <= alloc_r - CNT_W'(1);
              status_r <= ST_OK;
            end else begin
              status_r <= ST_COUNT_ZERO;
            end
            state_r <= (count_r >= CW'(RING_DEPTH)) ? S_DRAIN_RD : S_PUSH;
          end
        end
        S_DRAIN_RD: begin
          state_r <= S_DRAIN_MAP;
        end
        S_DRAIN_MAP: begin
          // pop the oldest entry and fetch its bitmap row
          head_r  <= ptr_inc(head_r);
          count_r <= count_r - CW'(1);
          row_r   <= ring_q[IDX_W-1:BIT_W];
          bit_r   <= ring_q[BIT_W-1:0];
          state_r <= S_DRAIN_CLR;
        end
        S_DRAIN_CLR: begin
          state_r <= (count_r > CW'(LEVEL)) ? S_DRAIN_RD : S_PUSH;
        end
        S_PUSH: begin
          tail_r        <= ptr_inc(tail_r);
          count_r       <= count_r + CW'(1);
          out_valid_r   <= 1'b1;
          out_status_r  <= status_r;
          out_granted_r <= '0;
          out_full_r    <= (alloc_r == total);
          out_empty_r   <= (alloc_r == '0);
          state_r       <= S_IDLE;
        end
        default: begin
          state_r <= S_CLEAR;
        end
      endcase
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_granted_r;
  assign out_slab_full     = out_full_r;
  assign out_slab_empty    = out_empty_r;

  // Assertions
  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(RING_DEPTH))
    else $error("ring count above ring depth");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !cfg_valid) |=> (busy || out_valid))
    else $error("accepted request neither in progress nor answered");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_granted_index == '0))
    else $error("index granted on a failed request");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> (busy && !out_valid && (count_r == '0)))
    else $error("configuration transfer did not restart the slab");

endmodule
